>>> design/hex_grid_pixel_pick_core_assert.svh
// ----------------------------------------------------------------------------
// Hexagon pixel pick: assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HEX_GRID_PIXEL_PICK_CORE_ASSERT_SVH
`define HEX_GRID_PIXEL_PICK_CORE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define HGPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define HGPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/hgpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hexagon pixel pick package
// Widths, register map, sequencer states and multiplier operation codes.
// ----------------------------------------------------------------------------
package hgpp_pkg;

    localparam int MAX_BOARD = 32;

    localparam int PT_W   = 16;
    localparam int BS_W   = 6;
    localparam int GEOM_W = 8;
    localparam int IDX_W  = 10;
    localparam int CXO_W  = 15;
    localparam int CYO_W  = 14;

    localparam int GEOM_MAX = (1 << GEOM_W) - 1;
    localparam int STEP_W   = GEOM_W + 1;
    localparam int STEP_MAX = 2 * GEOM_MAX;

    localparam int SZ_W  = $clog2(MAX_BOARD + 1);
    localparam int CNT_W = (2 * SZ_W > IDX_W) ? 2 * SZ_W : IDX_W;

    localparam int CX_RAW = $clog2(2 * MAX_BOARD * STEP_MAX + 1);
    localparam int CX_W   = (CX_RAW > CXO_W) ? CX_RAW : CXO_W;
    localparam int CY_RAW = $clog2(MAX_BOARD * GEOM_MAX + 1) + 1;
    localparam int CY_W   = (CY_RAW > CYO_W) ? CY_RAW : CYO_W;

    localparam int MA_W  = PT_W + 2;
    localparam int MB_W  = GEOM_W + 1;
    localparam int MUL_W = MA_W + MB_W;
    localparam int ACC_W =
        $clog2(GEOM_MAX * ((1 << PT_W) + 2 * MAX_BOARD * STEP_MAX) + 1) + 3;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [BS_W-1:0]   RST_BOARD_SIZE      = BS_W'(11);
    localparam logic [GEOM_W-1:0] RST_HEX_RADIUS      = GEOM_W'(30);
    localparam logic [GEOM_W-1:0] RST_HEX_HALF_WIDTH  = GEOM_W'(15);
    localparam logic [GEOM_W-1:0] RST_HEX_HALF_HEIGHT = GEOM_W'(26);

    typedef enum logic [1:0] {
        REG_BOARD_SIZE,
        REG_HEX_RADIUS,
        REG_HEX_HALF_WIDTH,
        REG_HEX_HALF_HEIGHT
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_P,
        MUL_Q,
        MUL_R,
        MUL_KHR,
        MUL_KWH,
        MUL_DP,
        MUL_DQ
    } mul_op_t;

endpackage

>>> design/hex_grid_pixel_pick_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hexagon board pixel pick core
// Finds the board cell holding a pixel and returns its index and centre.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries point_x and point_y. Output
//   channel (out_valid/out_ready) carries hit, cell_index, center_x and
//   center_y. The APB port holds board size and hexagon geometry; write it
//   only while no item is in flight.
//   An item first forms its setup products on a single shared 18x9
//   multiplier (edge products of the point, the edge bounds h*r and w*h
//   and the per-cell step values), then tests one cell per cycle, row by
//   row, by stepping the edge terms of the cell test. The number of cells
//   tried is the position of the hit cell, or size*size on a miss (1024
//   for a full 32 by 32 board). One item is in work at a time, so a new
//   item is taken only once the previous one has left the sequencer;
//   in_ready is high whenever the sequencer is idle.
//   The result sits in an output register, so a new item is taken while the
//   previous result waits; a stalled receiver holds the next result in the
//   sequencer until the output register frees.
//   Reset loads the default geometry and empties the block.
// ----------------------------------------------------------------------------
module hex_grid_pixel_pick_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [hgpp_pkg::PT_W-1:0]  point_x,
    input  logic signed [hgpp_pkg::PT_W-1:0]  point_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hit,
    output logic        [hgpp_pkg::IDX_W-1:0] cell_index,
    output logic        [hgpp_pkg::CXO_W-1:0] center_x,
    output logic signed [hgpp_pkg::CYO_W-1:0] center_y,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic        [hgpp_pkg::APB_AW-1:0] paddr,
    input  logic        [hgpp_pkg::APB_DW-1:0] pwdata,
    output logic        [hgpp_pkg::APB_DW-1:0] prdata,
    output logic                              pready
);
    import hgpp_pkg::*;

    // configuration
    logic [BS_W-1:0]   board_size_reg;
    logic [GEOM_W-1:0] hex_radius_reg;
    logic [GEOM_W-1:0] hex_half_width_reg;
    logic [GEOM_W-1:0] hex_half_height_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    // sequencer
    state_t  state_reg, state_next;
    mul_op_t op_reg, op_next;

    // item working set
    logic signed [PT_W-1:0]  pt_x_reg, pt_x_next;
    logic signed [PT_W-1:0]  pt_y_reg, pt_y_next;
    logic signed [ACC_W-1:0] acc_p_reg, acc_p_next;
    logic signed [ACC_W-1:0] acc_q_reg, acc_q_next;
    logic signed [ACC_W-1:0] acc_r_reg, acc_r_next;
    logic signed [ACC_W-1:0] base_p_reg, base_p_next;
    logic signed [ACC_W-1:0] base_q_reg, base_q_next;
    logic signed [ACC_W-1:0] base_r_reg, base_r_next;
    logic signed [ACC_W-1:0] khr_reg, khr_next;
    logic signed [ACC_W-1:0] kwh_reg, kwh_next;
    logic signed [ACC_W-1:0] dp_reg, dp_next;
    logic signed [ACC_W-1:0] dq_reg, dq_next;
    logic        [CX_W-1:0]  cx_reg, cx_next;
    logic        [CX_W-1:0]  cxb_reg, cxb_next;
    logic signed [CY_W-1:0]  cy_reg, cy_next;
    logic signed [CY_W-1:0]  cyb_reg, cyb_next;
    logic        [SZ_W-1:0]  i_reg, i_next;
    logic        [SZ_W-1:0]  j_reg, j_next;
    logic        [CNT_W-1:0] idx_reg, idx_next;
    logic                    found_reg, found_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic                    hit_reg, hit_next;
    logic        [IDX_W-1:0] cell_index_reg, cell_index_next;
    logic        [CXO_W-1:0] center_x_reg, center_x_next;
    logic signed [CYO_W-1:0] center_y_reg, center_y_next;

    // derived geometry
    logic        [STEP_W-1:0] step_x;
    logic signed [MB_W-1:0]   a_coef;
    logic signed [MB_W-1:0]   h_s;
    logic signed [MB_W-1:0]   w_s;
    logic        [7:0]        size_wide;
    logic        [7:0]        size_sat;
    logic        [SZ_W-1:0]   size_eff;
    logic        [SZ_W-1:0]   size_m1;
    logic signed [CY_W-1:0]   h_cy;

    // shared multiplier
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MUL_W-1:0] mul_p;
    logic signed [ACC_W-1:0] mul_ext;

    // cell test
    logic signed [ACC_W:0] sum_pq, dif_pq, r_e, khr_e, kwh_e, neg_khr, neg_kwh;
    logic                  cell_hit;
    logic                  last_i, last_j, out_free;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_size_reg      <= RST_BOARD_SIZE;
            hex_radius_reg      <= RST_HEX_RADIUS;
            hex_half_width_reg  <= RST_HEX_HALF_WIDTH;
            hex_half_height_reg <= RST_HEX_HALF_HEIGHT;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_BOARD_SIZE:      board_size_reg      <= pwdata[BS_W-1:0];
                REG_HEX_RADIUS:      hex_radius_reg      <= pwdata[GEOM_W-1:0];
                REG_HEX_HALF_WIDTH:  hex_half_width_reg  <= pwdata[GEOM_W-1:0];
                REG_HEX_HALF_HEIGHT: hex_half_height_reg <= pwdata[GEOM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_BOARD_SIZE:      prdata = APB_DW'(board_size_reg);
            REG_HEX_RADIUS:      prdata = APB_DW'(hex_radius_reg);
            REG_HEX_HALF_WIDTH:  prdata = APB_DW'(hex_half_width_reg);
            REG_HEX_HALF_HEIGHT: prdata = APB_DW'(hex_half_height_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Geometry
    // ------------------------------------------------------------------
    assign step_x = {1'b0, hex_radius_reg} + {1'b0, hex_half_width_reg};
    assign h_s    = $signed({1'b0, hex_half_height_reg});
    assign w_s    = $signed({1'b0, hex_half_width_reg});
    assign a_coef = w_s - $signed({1'b0, hex_radius_reg});
    assign h_cy   = $signed({{(CY_W-GEOM_W){1'b0}}, hex_half_height_reg});

    // saturate the board size to the largest board supported
    assign size_wide = {{(8-BS_W){1'b0}}, board_size_reg};
    assign size_sat  = (size_wide > 8'(MAX_BOARD)) ? 8'(MAX_BOARD) : size_wide;
    assign size_eff  = size_sat[SZ_W-1:0];
    assign size_m1   = size_eff - SZ_W'(1);

    // ------------------------------------------------------------------
    // Shared multiplier: one product per setup cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op_reg)
            MUL_P:
            begin
                mul_a = {{(MA_W-PT_W){pt_x_reg[PT_W-1]}}, pt_x_reg};
                mul_b = h_s;
            end
            MUL_Q:
            begin
                mul_a = {{(MA_W-PT_W){pt_y_reg[PT_W-1]}}, pt_y_reg};
                mul_b = a_coef;
            end
            MUL_R:
            begin
                mul_a = {{(MA_W-PT_W){pt_y_reg[PT_W-1]}}, pt_y_reg};
                mul_b = w_s;
            end
            MUL_KHR:
            begin
                mul_a = $signed({{(MA_W-GEOM_W){1'b0}}, hex_radius_reg});
                mul_b = h_s;
            end
            MUL_KWH:
            begin
                mul_a = $signed({{(MA_W-GEOM_W){1'b0}}, hex_half_width_reg});
                mul_b = h_s;
            end
            MUL_DP:
            begin
                mul_a = $signed({{(MA_W-STEP_W){1'b0}}, step_x});
                mul_b = h_s;
            end
            MUL_DQ:
            begin
                mul_a = $signed({{(MA_W-GEOM_W){1'b0}}, hex_half_height_reg});
                mul_b = a_coef;
            end
            default: ;
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign mul_ext = {{(ACC_W-MUL_W){mul_p[MUL_W-1]}}, mul_p};

    // ------------------------------------------------------------------
    // Cell test. With P = h*dx, Q = (w-r)*dy and R = w*dy taken against
    // the cell centre, the edge tests against the hexagon sides reduce to
    // |P-Q| <= h*r, |P+Q| <= h*r and |R| <= w*h.
    // ------------------------------------------------------------------
    assign sum_pq  = (ACC_W+1)'(acc_p_reg) + (ACC_W+1)'(acc_q_reg);
    assign dif_pq  = (ACC_W+1)'(acc_p_reg) - (ACC_W+1)'(acc_q_reg);
    assign r_e     = (ACC_W+1)'(acc_r_reg);
    assign khr_e   = (ACC_W+1)'(khr_reg);
    assign kwh_e   = (ACC_W+1)'(kwh_reg);
    assign neg_khr = -khr_e;
    assign neg_kwh = -kwh_e;

    assign cell_hit = (dif_pq <= khr_e) && (dif_pq >= neg_khr) &&
                      (sum_pq <= khr_e) && (sum_pq >= neg_khr) &&
                      (r_e <= kwh_e) && (r_e >= neg_kwh);

    assign last_i   = (i_reg == size_m1);
    assign last_j   = (j_reg == size_m1);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pt_x_next       = pt_x_reg;
        pt_y_next       = pt_y_reg;
        acc_p_next      = acc_p_reg;
        acc_q_next      = acc_q_reg;
        acc_r_next      = acc_r_reg;
        base_p_next     = base_p_reg;
        base_q_next     = base_q_reg;
        base_r_next     = base_r_reg;
        khr_next        = khr_reg;
        kwh_next        = kwh_reg;
        dp_next         = dp_reg;
        dq_next         = dq_reg;
        cx_next         = cx_reg;
        cxb_next        = cxb_reg;
        cy_next         = cy_reg;
        cyb_next        = cyb_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        hit_next        = hit_reg;
        cell_index_next = cell_index_reg;
        center_x_next   = center_x_reg;
        center_y_next   = center_y_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pt_x_next  = point_x;
                    pt_y_next  = point_y;
                    cx_next    = '0;
                    cxb_next   = '0;
                    cy_next    = '0;
                    cyb_next   = '0;
                    i_next     = '0;
                    j_next     = '0;
                    idx_next   = '0;
                    found_next = 1'b0;
                    op_next    = MUL_P;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                unique case (op_reg)
                    MUL_P:
                    begin
                        acc_p_next  = mul_ext;
                        base_p_next = mul_ext;
                    end
                    MUL_Q:
                    begin
                        acc_q_next  = mul_ext;
                        base_q_next = mul_ext;
                    end
                    MUL_R:
                    begin
                        acc_r_next  = mul_ext;
                        base_r_next = mul_ext;
                    end
                    MUL_KHR: khr_next = mul_ext;
                    MUL_KWH: kwh_next = mul_ext;
                    MUL_DP:  dp_next  = mul_ext;
                    MUL_DQ:  dq_next  = mul_ext;
                    default: ;
                endcase
                if (op_reg == MUL_DQ)
                begin
                    // an empty board has no cells to try
                    state_next = (size_eff == '0) ? ST_DONE : ST_SCAN;
                end
                else
                begin
                    op_next = mul_op_t'(op_reg + 3'd1);
                end
            end
            ST_SCAN:
            begin
                if (cell_hit)
                begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
                else if (last_i && last_j)
                begin
                    state_next = ST_DONE;
                end
                else if (last_i)
                begin
                    // next row: dx drops by the step, dy rises by h
                    i_next      = '0;
                    j_next      = j_reg + SZ_W'(1);
                    idx_next    = idx_reg + CNT_W'(1);
                    base_p_next = base_p_reg - dp_reg;
                    base_q_next = base_q_reg + dq_reg;
                    base_r_next = base_r_reg + kwh_reg;
                    acc_p_next  = base_p_reg - dp_reg;
                    acc_q_next  = base_q_reg + dq_reg;
                    acc_r_next  = base_r_reg + kwh_reg;
                    cxb_next    = cxb_reg + CX_W'(step_x);
                    cx_next     = cxb_reg + CX_W'(step_x);
                    cyb_next    = cyb_reg - h_cy;
                    cy_next     = cyb_reg - h_cy;
                end
                else
                begin
                    // next column: dx and dy both drop
                    i_next     = i_reg + SZ_W'(1);
                    idx_next   = idx_reg + CNT_W'(1);
                    acc_p_next = acc_p_reg - dp_reg;
                    acc_q_next = acc_q_reg - dq_reg;
                    acc_r_next = acc_r_reg - kwh_reg;
                    cx_next    = cx_reg + CX_W'(step_x);
                    cy_next    = cy_reg + h_cy;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    hit_next        = found_reg;
                    cell_index_next = found_reg ? idx_reg[IDX_W-1:0] : '0;
                    center_x_next   = found_reg ? cx_reg[CXO_W-1:0] : '0;
                    center_y_next   = found_reg ? cy_reg[CYO_W-1:0] : '0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= MUL_P;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_x_reg       <= pt_x_next;
        pt_y_reg       <= pt_y_next;
        acc_p_reg      <= acc_p_next;
        acc_q_reg      <= acc_q_next;
        acc_r_reg      <= acc_r_next;
        base_p_reg     <= base_p_next;
        base_q_reg     <= base_q_next;
        base_r_reg     <= base_r_next;
        khr_reg        <= khr_next;
        kwh_reg        <= kwh_next;
        dp_reg         <= dp_next;
        dq_reg         <= dq_next;
        cx_reg         <= cx_next;
        cxb_reg        <= cxb_next;
        cy_reg         <= cy_next;
        cyb_reg        <= cyb_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        idx_reg        <= idx_next;
        found_reg      <= found_next;
        hit_reg        <= hit_next;
        cell_index_reg <= cell_index_next;
        center_x_reg   <= center_x_next;
        center_y_reg   <= center_y_next;
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign cell_index = cell_index_reg;
    assign center_x   = center_x_reg;
    assign center_y   = center_y_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "hex_grid_pixel_pick_core_assert.svh"

    `HGPP_ASSERT_NEXT(a_accept_starts_setup, in_valid && in_ready, state_reg == ST_SETUP, "accepted item did not start setup")
    `HGPP_ASSERT_NOW(a_miss_fields_zero, out_valid && !hit, cell_index == '0 && center_x == '0 && center_y == '0, "miss result carries non-zero fields")
    `HGPP_ASSERT_NOW(a_scan_in_board, state_reg == ST_SCAN, i_reg < size_eff && j_reg < size_eff, "scan position outside the board")
    `HGPP_ASSERT_NOW(a_result_from_done, $rose(out_valid_reg), $past(state_reg) == ST_DONE, "result loaded outside the done state")

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hexagon board pixel pick testbench
// Drives points into the pick core under several board geometries, written
// over the APB port between phases. A scoreboard scans the board itself
// for every accepted point and checks each returned item in order.
// ----------------------------------------------------------------------------
module tb;
    import hgpp_pkg::*;

    localparam int HEX_SIDES = 6;

    typedef logic signed [PT_W-1:0]  coord_t;
    typedef logic        [IDX_W-1:0] cell_idx_t;
    typedef logic        [CXO_W-1:0] centre_x_t;
    typedef logic signed [CYO_W-1:0] centre_y_t;

    typedef struct {
        logic      hit;
        cell_idx_t cell_index;
        centre_x_t center_x;
        centre_y_t center_y;
    } pick_t;

    class pick_scoreboard;
        logic [BS_W-1:0]   board_size = 6'd11;
        logic [GEOM_W-1:0] radius     = 8'd30;
        logic [GEOM_W-1:0] half_w     = 8'd15;
        logic [GEOM_W-1:0] half_h     = 8'd26;
        pick_t             pending[$];
        int                errors;
        int                checked;

        function void set_reg(reg_idx_t idx, logic [APB_DW-1:0] word);
            case (idx)
                REG_BOARD_SIZE:      board_size = word[BS_W-1:0];
                REG_HEX_RADIUS:      radius     = word[GEOM_W-1:0];
                REG_HEX_HALF_WIDTH:  half_w     = word[GEOM_W-1:0];
                REG_HEX_HALF_HEIGHT: half_h     = word[GEOM_W-1:0];
                default: ;
            endcase
        endfunction

        // edges walked anticlockwise; a point on an edge gives a zero product
        function bit cell_holds(longint ox, longint oy, longint px, longint py);
            longint vx[HEX_SIDES];
            longint vy[HEX_SIDES];
            longint r, w, h, ex, ey, dx, dy;
            int     n;
            r = longint'(radius);
            w = longint'(half_w);
            h = longint'(half_h);
            vx[0] = ox + r; vy[0] = oy;
            vx[1] = ox + w; vy[1] = oy + h;
            vx[2] = ox - w; vy[2] = oy + h;
            vx[3] = ox - r; vy[3] = oy;
            vx[4] = ox - w; vy[4] = oy - h;
            vx[5] = ox + w; vy[5] = oy - h;
            for (int k = 0; k < HEX_SIDES; k++)
            begin
                n  = (k + 1) % HEX_SIDES;
                ex = vx[n] - vx[k];
                ey = vy[n] - vy[k];
                dx = px - vx[k];
                dy = py - vy[k];
                if (ex * dy - ey * dx < 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function pick_t pick_cell(coord_t px, coord_t py);
            pick_t  res;
            longint size, step_x, step_y, cx, cy;
            res    = '{1'b0, '0, '0, '0};
            size   = longint'(board_size);
            if (size > MAX_BOARD)
                size = MAX_BOARD;
            step_x = longint'(radius) + longint'(half_w);
            step_y = longint'(half_h);
            // row outer, column inner: the first cell found wins
            for (longint j = 0; j < size; j++)
            begin
                for (longint i = 0; i < size; i++)
                begin
                    cx = (i + j) * step_x;
                    cy = (i - j) * step_y;
                    if (cell_holds(cx, cy, longint'(px), longint'(py)))
                    begin
                        res.hit        = 1'b1;
                        res.cell_index = cell_idx_t'(j * size + i);
                        res.center_x   = centre_x_t'(cx);
                        res.center_y   = centre_y_t'(cy);
                        return res;
                    end
                end
            end
            return res;
        endfunction

        function void note_point(coord_t px, coord_t py);
            pending.push_back(pick_cell(px, py));
        endfunction

        task report_mismatch(string msg);
            $display("%0t: result %0d: %s", $time, checked, msg);
            errors++;
        endtask

        task check_result(logic hit, cell_idx_t idx, centre_x_t cx, centre_y_t cy);
            pick_t want;
            checked++;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item hit %b cell %0d", hit, idx));
                return;
            end
            want = pending.pop_front();
            if (hit !== want.hit)
                report_mismatch($sformatf("hit %b, expected %b", hit, want.hit));
            if (idx !== want.cell_index)
                report_mismatch($sformatf("cell_index %0d, expected %0d",
                                          idx, want.cell_index));
            if (cx !== want.center_x)
                report_mismatch($sformatf("center_x %0d, expected %0d",
                                          cx, want.center_x));
            if (cy !== want.center_y)
                report_mismatch($sformatf("center_y %0d, expected %0d",
                                          cy, want.center_y));
        endtask
    endclass

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int END_WAIT    = 1100;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    coord_t            point_x   = '0;
    coord_t            point_y   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              hit;
    cell_idx_t         cell_index;
    centre_x_t         center_x;
    centre_y_t         center_y;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [APB_DW-1:0] pwdata    = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    pick_scoreboard    sb;
    idle_mode_t        idle_mode   = IDLE_NONE;
    int                cycle_count = 0;

    hex_grid_pixel_pick_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .cell_index (cell_index),
        .center_x   (center_x),
        .center_y   (center_y),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic bit pause_now(bit is_sender);
        int pct;
        case (idle_mode)
            IDLE_SENDER:   pct = is_sender ? 73 : 0;
            IDLE_RECEIVER: pct = is_sender ? 0 : 73;
            IDLE_BOTH:     pct = 9;
            default:       pct = 0;
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    // check returned items, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(hit, cell_index, center_x, center_y);
        out_ready <= !pause_now(1'b0);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout, %0d items outstanding", sb.pending.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // setup then access; psel stays high across back-to-back writes
    task automatic apb_write(reg_idx_t idx, int value);
        logic [APB_DW-1:0] word;
        word = $urandom();
        if (idx == REG_BOARD_SIZE)
            word[BS_W-1:0] = value[BS_W-1:0];
        else
            word[GEOM_W-1:0] = value[GEOM_W-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, word);
    endtask

    task automatic configure(int size, int r, int w, int h);
        apb_write(REG_BOARD_SIZE, size);
        apb_write(REG_HEX_RADIUS, r);
        apb_write(REG_HEX_HALF_WIDTH, w);
        apb_write(REG_HEX_HALF_HEIGHT, h);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // hold valid and payload until the item is taken; valid is left high
    task automatic send_point(int x, int y);
        while (pause_now(1'b1))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x  <= coord_t'(x);
        point_y  <= coord_t'(y);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_point(coord_t'(x), coord_t'(y));
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // mostly points in or on a chosen cell, the rest near the board or noise
    task automatic send_random_point();
        int lim, i, j, r, w, h, cx, cy, x, y;
        r   = int'(sb.radius);
        w   = int'(sb.half_w);
        h   = int'(sb.half_h);
        lim = (sb.board_size > MAX_BOARD) ? MAX_BOARD : int'(sb.board_size);
        if (lim == 0)
            lim = 1;
        i  = $urandom_range(0, lim - 1);
        j  = $urandom_range(0, lim - 1);
        cx = (i + j) * (r + w);
        cy = (i - j) * h;
        case ($urandom_range(0, 9))
            0:
            begin
                x = int'(coord_t'($urandom()));
                y = int'(coord_t'($urandom()));
            end
            1:
            begin
                x = int'($urandom_range(0, 2 * lim * (r + w) + 600)) - 300;
                y = int'($urandom_range(0, 2 * lim * h + 600)) - lim * h - 300;
            end
            2, 3:
            begin
                case ($urandom_range(0, 5))
                    0:       begin x = cx + r; y = cy;     end
                    1:       begin x = cx + w; y = cy + h; end
                    2:       begin x = cx - w; y = cy + h; end
                    3:       begin x = cx - r; y = cy;     end
                    4:       begin x = cx - w; y = cy - h; end
                    default: begin x = cx + w; y = cy - h; end
                endcase
                // nudge off the vertex now and then
                if ($urandom_range(0, 1))
                begin
                    x = x + int'($urandom_range(0, 2)) - 1;
                    y = y + int'($urandom_range(0, 2)) - 1;
                end
            end
            4:
            begin
                x = cx + int'($urandom_range(0, 2 * w)) - w;
                y = $urandom_range(0, 1) ? cy + h : cy - h;
            end
            default:
            begin
                x = cx + int'($urandom_range(0, 2 * r)) - r;
                y = cy + int'($urandom_range(0, 2 * h)) - h;
            end
        endcase
        send_point(x, y);
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return GEOM_MAX;
            default: return $urandom_range(1, GEOM_MAX);
        endcase
    endfunction

    initial
    begin
        int size, r, w, items;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: centres, vertices, shared edges, far corners
        send_point(0, 0);
        send_point(30, 0);
        send_point(-30, 0);
        send_point(15, 26);
        send_point(-15, -26);
        send_point(0, 26);
        send_point(22, 13);
        send_point(-31, 0);
        send_point(900, 0);
        send_point(450, 260);
        send_point(450, -260);
        send_point(-32768, -32768);
        send_point(32767, 32767);
        send_point(-32768, 32767);
        send_point(32767, -32768);
        wait_all_results();

        // oversized board saturates, largest geometry
        configure(63, GEOM_MAX, GEOM_MAX, GEOM_MAX);
        send_point(0, 0);
        send_point(31620, 0);
        send_point(-32768, 0);
        wait_all_results();

        // empty board never hits
        configure(0, 30, 15, 26);
        send_point(0, 0);
        wait_all_results();

        // collapsed hexagon: every cross product is zero
        configure(1, 0, 0, 0);
        send_point(0, 0);
        send_point(5, -7);
        wait_all_results();

        // half width beyond the radius
        configure(2, 10, 40, 1);
        send_point(0, 0);
        send_point(50, 1);
        wait_all_results();

        for (int p = 0; p < 8; p++)
        begin
            if (p == 2)
            begin
                size  = $urandom_range(32, 63);
                items = 10;
            end
            else if (p == 6)
            begin
                size  = 0;
                items = 10;
            end
            else
            begin
                size  = $urandom_range(1, 10);
                items = 90;
            end
            r = pick_dim();
            w = $urandom_range(0, 1) ? int'($urandom_range(0, r)) : pick_dim();
            configure(size, r, w, pick_dim());
            idle_mode = idle_mode_t'(p % 4);
            for (int n = 0; n < items; n++)
            begin
                // hold off once per phase until the block has drained
                if (n == items / 2)
                    wait_all_results();
                send_random_point();
            end
            wait_all_results();
        end

        idle_mode = IDLE_NONE;
        repeat (END_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
